/* hw/rtl/handle_pool_allocator_assert.svh */
// Assertion macros for the handle pool allocator checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HANDLE_POOL_ALLOCATOR_ASSERT_SVH
`define HANDLE_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define HPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("handle pool allocator check failed");

// Next-cycle implication, sampled on clk, off during reset
`define HPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("handle pool allocator check failed");

`endif

/* hw/rtl/hpa_pkg.sv */
// Shared types and constants for the handle pool allocator.
// No dependencies; imported by hpa_ctrl, hpa_dpath, the top level and the checker.
`default_nettype none

package hpa_pkg;

  // Pool geometry
  localparam int MAX_HANDLES = 1024;
  localparam int DATA_BITS   = 32;
  localparam int HANDLE_W    = 10;
  localparam int ADDR_W      = $clog2(MAX_HANDLES);
  localparam int CNT_W       = ADDR_W + 1;

  // Request codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_EMPTY      = 2'd1;
  localparam logic [1:0] STS_NOT_IN_USE = 2'd2;

  // Request beat
  typedef struct packed {
    logic [1:0]           op;
    logic [HANDLE_W-1:0]  handle;
    logic [DATA_BITS-1:0] data_in;
  } hpa_in_t;

  // Result beat
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle_out;
    logic [DATA_BITS-1:0] data_out;
    logic [1:0]           status;
  } hpa_out_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } hpa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture request
    logic read;   // issue memory reads
    logic exec;   // commit update, show result
    logic clear;  // write one in-use entry to zero
  } hpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing sweep is at its last entry
  } hpa_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/hpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hpa_ctrl.sv */
// Sequencer for the handle pool allocator: clear sweep, read, execute.
// Depends on hpa_pkg.
`default_nettype none

module hpa_ctrl
  import hpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire hpa_sts_t sts,
  output logic          busy,
  output logic          out_valid,
  output hpa_cmd_t      cmd
);

  hpa_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start)        state_nxt = S_READ;
      S_READ:                    state_nxt = S_EXEC;
      S_EXEC:                    state_nxt = S_IDLE;
      default:                   state_nxt = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_READ:  cmd.read = 1'b1;
      S_EXEC: begin
        cmd.exec  = 1'b1;
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/hpa_dpath.sv */
// Datapath: request register, counters, free stack, data table, in-use map.
// Depends on hpa_pkg and hpa_ram.
`default_nettype none

module hpa_dpath
  import hpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire hpa_in_t  in_req,
  input  wire hpa_cmd_t cmd,
  output hpa_sts_t      sts,
  output hpa_out_t      res
);

  hpa_in_t           req_r;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] clr_idx_r;

  logic [HANDLE_W-1:0]  stack_rd;
  logic [DATA_BITS-1:0] data_rd;
  logic [0:0]           inuse_rd;

  logic              alloc_ok, free_ok;
  logic [ADDR_W-1:0] grant;

  logic              inuse_we;
  logic [ADDR_W-1:0] inuse_waddr;
  logic [0:0]        inuse_wdata;

  // Request capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r   <= '0;
      count_r   <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.exec) begin
        fresh_r <= fresh_nxt;
        count_r <= count_nxt;
      end
      if (cmd.clear) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  assign sts.clr_last = (clr_idx_r == ADDR_W'(MAX_HANDLES - 1));

  // Decide the request from the read data
  always_comb begin
    alloc_ok       = 1'b0;
    free_ok        = 1'b0;
    grant          = '0;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    res.handle_out = req_r.handle;
    res.data_out   = '0;
    res.status     = STS_OK;
    case (req_r.op)
      OP_ALLOC: begin
        if (count_r != '0) begin
          // reuse most recently freed handle
          grant     = stack_rd[ADDR_W-1:0];
          alloc_ok  = 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (fresh_r != CNT_W'(MAX_HANDLES)) begin
          grant     = fresh_r[ADDR_W-1:0];
          alloc_ok  = 1'b1;
          fresh_nxt = fresh_r + 1'b1;
        end
        if (alloc_ok) begin
          res.handle_out = HANDLE_W'(grant);
        end else begin
          res.handle_out = '0;
          res.status     = STS_EMPTY;
        end
      end
      OP_FREE: begin
        if (inuse_rd[0] && (count_r != CNT_W'(MAX_HANDLES))) begin
          free_ok   = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          res.status = STS_NOT_IN_USE;
        end
      end
      OP_GET: begin
        if (inuse_rd[0]) begin
          res.data_out = data_rd;
        end else begin
          res.status = STS_NOT_IN_USE;
        end
      end
      default: ;
    endcase
  end

  // In-use write mux: clear sweep, grant, release
  always_comb begin
    inuse_we    = 1'b0;
    inuse_waddr = clr_idx_r;
    inuse_wdata = 1'b0;
    if (cmd.clear) begin
      inuse_we = 1'b1;
    end else if (cmd.exec && alloc_ok) begin
      inuse_we    = 1'b1;
      inuse_waddr = grant;
      inuse_wdata = 1'b1;
    end else if (cmd.exec && free_ok) begin
      inuse_we    = 1'b1;
      inuse_waddr = req_r.handle[ADDR_W-1:0];
    end
  end

  // Free stack
  hpa_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (MAX_HANDLES)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.exec && free_ok),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (req_r.handle),
    .re    (cmd.read),
    .raddr (count_r[ADDR_W-1:0] - 1'b1),
    .rdata (stack_rd)
  );

  // Data table
  hpa_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MAX_HANDLES)
  ) u_data (
    .clk   (clk),
    .we    (cmd.exec && alloc_ok),
    .waddr (grant),
    .wdata (req_r.data_in),
    .re    (cmd.read),
    .raddr (req_r.handle[ADDR_W-1:0]),
    .rdata (data_rd)
  );

  // In-use map
  hpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_HANDLES)
  ) u_inuse (
    .clk   (clk),
    .we    (inuse_we),
    .waddr (inuse_waddr),
    .wdata (inuse_wdata),
    .re    (cmd.read),
    .raddr (req_r.handle[ADDR_W-1:0]),
    .rdata (inuse_rd)
  );

endmodule

`default_nettype wire

/* hw/rtl/handle_pool_allocator.sv */
// Handle pool allocator top level: controller plus datapath.
// Depends on hpa_pkg, hpa_ctrl, hpa_dpath (and hpa_ram below it).
//
//   channel  | ports                    | handshake
//   request  | start, busy, in_req      | beat taken when start && !busy
//   result   | out_valid, out_res       | one-cycle strobe, no back-pressure
//
// Each request passes through capture, then memory read, then execute and result.
// The single registered read port of each memory is why the read step is separate.
// After reset busy stays high while the whole in-use map is swept to zero.
// Result strobe is high in S_EXEC, which follows S_READ after the accepting edge; no stall.
`default_nettype none

module handle_pool_allocator
  import hpa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire hpa_in_t in_req,
  output logic         out_valid,
  output hpa_out_t     out_res
);

  hpa_cmd_t cmd;
  hpa_sts_t sts;

  // Sequencer
  hpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Storage and decision logic
  hpa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .sts    (sts),
    .res    (out_res)
  );

endmodule

`default_nettype wire

/* hw/rtl/hpa_checker.sv */
// Port-level checks for the handle pool allocator, bound to the top level.
// Depends on hpa_pkg and handle_pool_allocator_assert.svh.
`default_nettype none

`include "handle_pool_allocator_assert.svh"

module hpa_checker
  import hpa_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire hpa_out_t out_res
);

  logic accept;
  assign accept = start && !busy;

  // accepted beat makes the block busy
  `HPA_ASSERT_NEXT(a_accept_busy, accept, busy)
  // result strobe follows acceptance once the memory read is done
  `HPA_ASSERT_IMPL(a_result_lat, accept, ##2 out_valid)
  // results only show while a request is in flight
  `HPA_ASSERT_IMPL(a_valid_busy, out_valid, busy)
  // an exhausted pool returns zero fields
  `HPA_ASSERT_IMPL(a_empty_zero, out_valid && (out_res.status == STS_EMPTY),
                   (out_res.handle_out == '0) && (out_res.data_out == '0))
  // data only on a successful get
  `HPA_ASSERT_IMPL(a_err_nodata, out_valid && (out_res.status != STS_OK),
                   out_res.data_out == '0)

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
